// ===== design/gbba_pkg.sv =====
`default_nettype none
package gbba_pkg;
  localparam int GroupBits = 4;
  localparam int WordIdxBits = 8;
  localparam int AddrBits = GroupBits + WordIdxBits;
  localparam int MemDepth = 4096;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_LOAD_WORD = 2'd1,
    OP_LOAD_COUNT = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_READ_ONLY = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_INCONSISTENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_BPG = 3'd0,
    REG_IPG = 3'd1,
    REG_GROUPS = 3'd2,
    REG_FIRST = 3'd3,
    REG_RO = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_GROUP, S_RDREQ, S_RDWAIT, S_CHECK, S_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;       // latch the input item, begin division
    logic load_word;   // write the bitmap memory
    logic load_count;  // update a group count
    logic div_step;    // one quotient bit
    logic goal_fix;    // clamp the goal into range
    logic grp_next;    // move to the next group
    logic word_next;   // advance word index
    logic commit;      // set the bit and update counts
    logic fin_ok;
    logic fin_status;  // finish with the status in cmd.st
    status_t st;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_t op;
    logic read_only;
    logic no_groups;
    logic div_done;
    logic group_free;   // current group count nonzero
    logic groups_done;  // all groups visited
    logic word_hit;     // usable clear bit in current word
    logic words_done;   // last word of the group checked
  } stat_t;
endpackage
`default_nettype wire

// ===== design/gbba_if.sv =====
`default_nettype none
interface gbba_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [17:0] inode_number;
  logic [3:0] group_index;
  logic [7:0] word_index;
  logic [31:0] word_data;
  logic [13:0] free_count;
  modport source(output valid, operation, inode_number, group_index, word_index,
                 word_data, free_count, input ready);
  modport sink(input valid, operation, inode_number, group_index, word_index,
               word_data, free_count, output ready);
endinterface

interface gbba_out_if;
  logic valid;
  logic ready;
  logic [17:0] block_number;
  logic [1:0] status;
  logic [17:0] total_free;
  modport source(output valid, block_number, status, total_free, input ready);
  modport sink(input valid, block_number, status, total_free, output ready);
endinterface
`default_nettype wire

// ===== design/gbba_ram.sv =====
`default_nettype none
module gbba_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/gbba_ctrl.sv =====
`default_nettype none
module gbba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                res_load,
  input  wire logic           out_busy,
  input  wire gbba_pkg::stat_t sts,
  output gbba_pkg::cmd_t      cmd
);
  gbba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= gbba_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gbba_pkg::S_IDLE: if (in_valid) state_next = gbba_pkg::S_DIV;
      gbba_pkg::S_DIV: begin
        if (sts.op != gbba_pkg::OP_ALLOC || sts.read_only || sts.no_groups)
          state_next = gbba_pkg::S_DONE;
        else if (sts.div_done) state_next = gbba_pkg::S_GROUP;
      end
      gbba_pkg::S_GROUP: begin
        if (sts.group_free) state_next = gbba_pkg::S_RDREQ;
        else if (sts.groups_done) state_next = gbba_pkg::S_DONE;
      end
      gbba_pkg::S_RDREQ: state_next = gbba_pkg::S_RDWAIT;
      gbba_pkg::S_RDWAIT: state_next = gbba_pkg::S_CHECK;
      gbba_pkg::S_CHECK: begin
        if (sts.word_hit || sts.words_done) state_next = gbba_pkg::S_DONE;
        else state_next = gbba_pkg::S_RDREQ;
      end
      gbba_pkg::S_DONE: if (!out_busy) state_next = gbba_pkg::S_IDLE;
      default: state_next = gbba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.st = gbba_pkg::ST_OK;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      gbba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      gbba_pkg::S_DIV: begin
        if (sts.op == gbba_pkg::OP_LOAD_WORD) cmd.load_word = 1'b1;
        else if (sts.op == gbba_pkg::OP_LOAD_COUNT) cmd.load_count = 1'b1;
        if (sts.op != gbba_pkg::OP_ALLOC) cmd.fin_status = 1'b1;
        else if (sts.read_only) begin
          cmd.fin_status = 1'b1; cmd.st = gbba_pkg::ST_READ_ONLY;
        end else if (sts.no_groups) begin
          cmd.fin_status = 1'b1; cmd.st = gbba_pkg::ST_NO_SPACE;
        end else if (sts.div_done) cmd.goal_fix = 1'b1;
        else cmd.div_step = 1'b1;
      end
      gbba_pkg::S_GROUP: begin
        if (!sts.group_free) begin
          if (sts.groups_done) begin
            cmd.fin_status = 1'b1; cmd.st = gbba_pkg::ST_NO_SPACE;
          end else cmd.grp_next = 1'b1;
        end
      end
      gbba_pkg::S_RDREQ: ;
      gbba_pkg::S_RDWAIT: ;
      gbba_pkg::S_CHECK: begin
        if (sts.word_hit) begin
          cmd.commit = 1'b1; cmd.fin_ok = 1'b1;
        end else if (sts.words_done) begin
          cmd.fin_status = 1'b1; cmd.st = gbba_pkg::ST_INCONSISTENT;
        end else cmd.word_next = 1'b1;
      end
      gbba_pkg::S_DONE: res_load = !out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/gbba_dp.sv =====
`default_nettype none
module gbba_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [13:0]     cfg_data,
  input  wire logic [1:0]      operation,
  input  wire logic [17:0]     inode_number,
  input  wire logic [3:0]      group_index,
  input  wire logic [7:0]      word_index,
  input  wire logic [31:0]     word_data,
  input  wire logic [13:0]     free_count,
  input  wire gbba_pkg::cmd_t  cmd,
  output gbba_pkg::stat_t      sts,
  output logic [17:0]          res_block,
  output logic [1:0]           res_status,
  output logic [17:0]          total_free
);
  logic [13:0] bpg, ipg;
  logic [4:0]  groups;
  logic        first_blk, ro;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpg <= 14'd8192; ipg <= 14'd2048; groups <= 5'd1; first_blk <= 1'b1; ro <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbba_pkg::REG_BPG: bpg <= cfg_data;
        gbba_pkg::REG_IPG: ipg <= cfg_data;
        gbba_pkg::REG_GROUPS: groups <= cfg_data[4:0];
        gbba_pkg::REG_FIRST: first_blk <= cfg_data[0];
        gbba_pkg::REG_RO: ro <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latched input item.
  logic [1:0]  op_q;
  logic [3:0]  gi_q;
  logic [7:0]  wi_q;
  logic [31:0] wd_q;
  logic [13:0] fc_q;

  // Restoring divider: (inode-1) / ipg, one quotient bit per cycle.
  logic [17:0] dividend, quot;
  logic [14:0] rem;
  logic [4:0]  div_cnt;
  logic        div_zero;
  logic [14:0] rem_sh, rem_sub;
  assign rem_sh  = {rem[13:0], dividend[17]};
  assign rem_sub = rem_sh - {1'b0, ipg};

  // Effective limits.
  logic [4:0]  cnt_eff;
  logic [13:0] bpg_eff;
  logic [8:0]  nwords;
  assign cnt_eff = (groups > 5'd16) ? 5'd16 : groups;
  assign bpg_eff = (bpg > 14'd8192) ? 14'd8192 : bpg;
  assign nwords  = bpg_eff[13:5];

  logic [3:0]  grp;
  logic [4:0]  visited;
  logic [8:0]  widx;
  logic [13:0] gfree [16];
  logic [17:0] tfree;

  // Bitmap memory and the word under test.
  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, rdata;
  gbba_ram #(.Width(32), .Depth(gbba_pkg::MemDepth)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rdata)
  );
  assign mem_raddr = {grp, widx[7:0]};

  // Lowest clear bit of the read word.
  logic [4:0] lz;
  logic       has_zero;
  always_comb begin
    lz = 5'd0;
    has_zero = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!rdata[i]) begin
        lz = 5'(i);
        has_zero = 1'b1;
      end
    end
  end
  logic [13:0] bitno;
  assign bitno = {widx[8:0], lz};  // 14 bits: widx<256 so fits
  // A group smaller than one word has no whole word to scan.
  logic hit;
  assign hit = has_zero && (bitno < bpg_eff) && (nwords != 9'd0);

  assign mem_we    = cmd.load_word || cmd.commit;
  assign mem_waddr = cmd.commit ? {grp, widx[7:0]} : {gi_q, wi_q};
  assign mem_wdata = cmd.commit ? (rdata | (32'd1 << lz)) : wd_q;

  // Block number: first + grp*bpg + bit; the product is a narrow multiply.
  logic [17:0] grp_base;
  assign grp_base = {14'd0, grp} * {4'd0, bpg};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q <= operation; gi_q <= group_index; wi_q <= word_index;
      wd_q <= word_data; fc_q <= free_count;
      dividend <= inode_number - 18'd1;
      div_zero <= (inode_number == 18'd0) || (ipg == 14'd0);
      rem <= '0; quot <= '0; div_cnt <= '0;
      visited <= '0; widx <= '0;
    end
    if (cmd.div_step) begin
      if (!rem_sub[14]) begin
        rem <= rem_sub; quot <= {quot[16:0], 1'b1};
      end else begin
        rem <= rem_sh; quot <= {quot[16:0], 1'b0};
      end
      dividend <= {dividend[16:0], 1'b0};
      div_cnt <= div_cnt + 5'd1;
    end
    if (cmd.goal_fix)
      grp <= (div_zero || quot >= {13'd0, cnt_eff}) ? 4'd0 : quot[3:0];
    if (cmd.grp_next) begin
      grp <= ({1'b0, grp} + 5'd1 >= cnt_eff) ? 4'd0 : grp + 4'd1;
      visited <= visited + 5'd1;
    end
    if (cmd.word_next) widx <= widx + 9'd1;
    if (cmd.fin_ok) begin
      res_block <= 18'({17'd0, first_blk} + grp_base + {4'd0, bitno});
      res_status <= gbba_pkg::ST_OK;
    end
    if (cmd.fin_status) begin
      res_block <= '0;
      res_status <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) gfree[i] <= '0;
      tfree <= '0;
    end else if (cmd.load_count) begin
      gfree[gi_q] <= fc_q;
      tfree <= tfree + {4'd0, fc_q} - {4'd0, gfree[gi_q]};
    end else if (cmd.commit) begin
      gfree[grp] <= gfree[grp] - 14'd1;
      tfree <= tfree - 18'd1;
    end
  end
  assign total_free = tfree;

  always_comb begin
    sts.op = gbba_pkg::op_t'(op_q);
    sts.read_only = ro;
    sts.no_groups = (cnt_eff == 5'd0);
    sts.div_done = (div_cnt == 5'd18);
    sts.group_free = (gfree[grp] != 14'd0);
    sts.groups_done = (visited + 5'd1 >= cnt_eff);
    sts.word_hit = hit;
    sts.words_done = (widx + 9'd1 >= nwords);
  end
endmodule
`default_nettype wire

// ===== design/group_bitmap_block_allocator.sv =====
`default_nettype none
// Block allocator over per-group allocation bitmaps held in a 4096 x 32 memory
// (16 groups of 256 words). Each transfer on the input channel is one
// operation: allocate, load a bitmap word, or load a group free count. Every
// operation yields exactly one result transfer carrying block number, status
// and the total free count. One item is worked on at a time. A load goes
// through the idle state that accepts it, a work state and a done state that
// loads the result register. An allocate goes through the accepting state, a
// bit-serial divider that finds the goal group, a group state per group visited
// (the group it allocates from included), a request, a wait and a check state
// per bitmap word read, and a state that loads the result register; a read-only
// refusal or a zero group count skips the divider. The next item is accepted
// right after the result register is loaded; while the previous result has
// not been taken, the block holds in its final state. Bitmap words never
// loaded are undefined; allocation must not reach them. Configuration must
// be written only while idle; the block itself does not enforce this.
module group_bitmap_block_allocator (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [2:0]  cfg_index,
  input wire logic [13:0] cfg_data,
  gbba_in_if.sink         in_ch,
  gbba_out_if.source      out_ch
);
  gbba_pkg::cmd_t  cmd;
  gbba_pkg::stat_t sts;
  logic res_load;
  logic [17:0] res_block, total_free;
  logic [1:0]  res_status;

  gbba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res_load(res_load), .out_busy(out_ch.valid), .sts(sts), .cmd(cmd)
  );

  gbba_dp u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .operation(in_ch.operation),
    .inode_number(in_ch.inode_number), .group_index(in_ch.group_index),
    .word_index(in_ch.word_index), .word_data(in_ch.word_data),
    .free_count(in_ch.free_count), .cmd(cmd), .sts(sts),
    .res_block(res_block), .res_status(res_status), .total_free(total_free)
  );

  // Output register: holds the result until the downstream transfer.
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (res_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_ch.block_number <= res_block;
      out_ch.status <= res_status;
      out_ch.total_free <= total_free;
    end
  end

  // A failed allocation never reports a block number.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != gbba_pkg::ST_OK |-> out_ch.block_number == 18'd0)
    else $error("nonzero block on failed status");
  // The bit is set and the counts drop only once per allocation.
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit)
    else $error("double commit");
  // A result is loaded only when the output register is free.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_ch.valid)
    else $error("result overrun");
endmodule
`default_nettype wire
